@@ rtl/core/assert_macros.svh @@
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every edge outside reset
`define CALDATE_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("%m: assertion failed");

// same-cycle implication
`define CALDATE_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: assertion failed");

// next-cycle implication
`define CALDATE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: assertion failed");

`endif

@@ rtl/core/caldate_pkg.sv @@
// types, constants and calendar helper functions for the date counter
package caldate_pkg;

   localparam int MAX_YEAR_DEF = 9999;

   localparam int DAY_W   = 5;
   localparam int MONTH_W = 4;
   localparam int YEAR_W  = 14;
   localparam int GAP_W   = 22;
   localparam int DN_W    = 23;
   localparam int YMOD_W  = 7;
   localparam int CENT_W  = 2;
   localparam int Q100_W  = 8;
   localparam int PROD_W  = 30;
   localparam int DBM_W   = 9;

   localparam logic [PROD_W-1:0] DIV25_MUL = PROD_W'(167773);
   localparam int                DIV25_SHIFT = 22;

   localparam logic [DN_W-1:0]  DN_RESET = DN_W'(730120);
   localparam logic [GAP_W-1:0] GAP_MAX  = '1;

   typedef enum logic [1:0] {
      FUNC_SET  = 2'd0,
      FUNC_NEXT = 2'd1,
      FUNC_PREV = 2'd2,
      FUNC_DIFF = 2'd3
   } func_type;

   typedef struct packed {
      logic                valid;
      func_type            func;
      logic [DAY_W-1:0]    day;
      logic [MONTH_W-1:0]  month;
      logic [YEAR_W-1:0]   year;
      logic                ok;
      logic [DN_W-1:0]     dn;
      logic [YMOD_W-1:0]   ymod;
      logic [CENT_W-1:0]   cent;
   } given_type;

   // floor(v / 100) as floor((v >> 2) / 25) by reciprocal
   function automatic logic [Q100_W-1:0] div100(input logic [YEAR_W-1:0] v);
      logic [PROD_W-1:0] prod;
      prod = PROD_W'(v[YEAR_W-1:2]) * DIV25_MUL;
      return prod[DIV25_SHIFT +: Q100_W];
   endfunction

   // leap from year mod 100 and low bits of year / 100
   function automatic logic is_leap(input logic [YMOD_W-1:0] ymod,
                                    input logic [CENT_W-1:0] cent);
      return (ymod[1:0] == 2'd0) && ((ymod != '0) || (cent == '0));
   endfunction

   function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
      logic [DAY_W-1:0] len;
      case (m)
         4'd1:    len = 5'd31;
         4'd2:    len = leap ? 5'd29 : 5'd28;
         4'd3:    len = 5'd31;
         4'd4:    len = 5'd30;
         4'd5:    len = 5'd31;
         4'd6:    len = 5'd30;
         4'd7:    len = 5'd31;
         4'd8:    len = 5'd31;
         4'd9:    len = 5'd30;
         4'd10:   len = 5'd31;
         4'd11:   len = 5'd30;
         4'd12:   len = 5'd31;
         default: len = 5'd0;
      endcase
      return len;
   endfunction

   function automatic logic [DBM_W-1:0] days_before(input logic [MONTH_W-1:0] m);
      logic [DBM_W-1:0] n;
      case (m)
         4'd1:    n = 9'd0;
         4'd2:    n = 9'd31;
         4'd3:    n = 9'd59;
         4'd4:    n = 9'd90;
         4'd5:    n = 9'd120;
         4'd6:    n = 9'd151;
         4'd7:    n = 9'd181;
         4'd8:    n = 9'd212;
         4'd9:    n = 9'd243;
         4'd10:   n = 9'd273;
         4'd11:   n = 9'd304;
         4'd12:   n = 9'd334;
         default: n = 9'd0;
      endcase
      return n;
   endfunction

endpackage

@@ rtl/core/caldate_daynum.sv @@
// request pipeline that checks the given date and forms its day number
module caldate_daynum #(
   parameter int MAX_YEAR = caldate_pkg::MAX_YEAR_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [1:0]                         req_func,
   input  logic [caldate_pkg::DAY_W-1:0]      req_in_day,
   input  logic [caldate_pkg::MONTH_W-1:0]    req_in_month,
   input  logic [caldate_pkg::YEAR_W-1:0]     req_in_year,
   input  logic                               down_stall,
   output caldate_pkg::given_type             given
);

   localparam int YW = caldate_pkg::YEAR_W;
   localparam int DW = caldate_pkg::DN_W;

   logic                              a_valid_ff, a_valid_in;
   caldate_pkg::func_type             a_func_ff;
   logic [caldate_pkg::DAY_W-1:0]     a_day_ff;
   logic [caldate_pkg::MONTH_W-1:0]   a_month_ff;
   logic [YW-1:0]                     a_year_ff;

   logic                              b_valid_ff, b_valid_in;
   caldate_pkg::func_type             b_func_ff;
   logic [caldate_pkg::DAY_W-1:0]     b_day_ff;
   logic [caldate_pkg::MONTH_W-1:0]   b_month_ff;
   logic [YW-1:0]                     b_year_ff;
   logic [caldate_pkg::Q100_W-1:0]    b_q100y_ff, b_q100y_in;
   logic [caldate_pkg::Q100_W-1:0]    b_q100p_ff, b_q100p_in;

   caldate_pkg::given_type            c_ff, c_in;

   logic          a_ok, b_ok, c_ok;
   logic [YW-1:0] a_prev_year, b_prev_year, b_ymod_full;
   logic          b_leap;

   assign c_ok      = !c_ff.valid || !down_stall;
   assign b_ok      = !b_valid_ff || c_ok;
   assign a_ok      = !a_valid_ff || b_ok;
   assign req_stall = !a_ok;

   assign a_valid_in = req_valid;
   assign b_valid_in = a_valid_ff;

   // stage a: year / 100 for the year and the year before
   assign a_prev_year = a_year_ff - YW'(1);
   assign b_q100y_in  = caldate_pkg::div100(a_year_ff);
   assign b_q100p_in  = caldate_pkg::div100(a_prev_year);

   // stage b: validity and closed-form day number
   assign b_prev_year = b_year_ff - YW'(1);
   assign b_ymod_full = b_year_ff - (YW'(b_q100y_ff) * YW'(100));
   assign b_leap      = caldate_pkg::is_leap(b_ymod_full[caldate_pkg::YMOD_W-1:0],
                                             b_q100y_ff[caldate_pkg::CENT_W-1:0]);

   always_comb begin
      c_in       = '0;
      c_in.valid = b_valid_ff;
      c_in.func  = b_func_ff;
      c_in.day   = b_day_ff;
      c_in.month = b_month_ff;
      c_in.year  = b_year_ff;
      c_in.ymod  = b_ymod_full[caldate_pkg::YMOD_W-1:0];
      c_in.cent  = b_q100y_ff[caldate_pkg::CENT_W-1:0];
      c_in.ok    = (b_year_ff >= YW'(1)) && (b_year_ff <= YW'(MAX_YEAR))
                   && (b_month_ff >= 4'd1) && (b_month_ff <= 4'd12)
                   && (b_day_ff >= 5'd1)
                   && (b_day_ff <= caldate_pkg::month_days(b_month_ff, b_leap));
      c_in.dn    = (DW'(b_prev_year) * DW'(365))
                   + DW'(b_prev_year[YW-1:2])
                   - DW'(b_q100p_ff)
                   + DW'(b_q100p_ff[caldate_pkg::Q100_W-1:2])
                   + DW'(caldate_pkg::days_before(b_month_ff))
                   + DW'(b_leap && (b_month_ff > 4'd2))
                   + DW'(b_day_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff  <= 1'b0;
         b_valid_ff  <= 1'b0;
         c_ff.valid  <= 1'b0;
      end else begin
         if (a_ok) begin
            a_valid_ff <= a_valid_in;
         end
         if (b_ok) begin
            b_valid_ff <= b_valid_in;
         end
         if (c_ok) begin
            c_ff.valid <= c_in.valid;
         end
      end
      if (a_ok) begin
         a_func_ff  <= caldate_pkg::func_type'(req_func);
         a_day_ff   <= req_in_day;
         a_month_ff <= req_in_month;
         a_year_ff  <= req_in_year;
      end
      if (b_ok) begin
         b_func_ff  <= a_func_ff;
         b_day_ff   <= a_day_ff;
         b_month_ff <= a_month_ff;
         b_year_ff  <= a_year_ff;
         b_q100y_ff <= b_q100y_in;
         b_q100p_ff <= b_q100p_in;
      end
      if (c_ok) begin
         c_ff.func  <= c_in.func;
         c_ff.day   <= c_in.day;
         c_ff.month <= c_in.month;
         c_ff.year  <= c_in.year;
         c_ff.ok    <= c_in.ok;
         c_ff.dn    <= c_in.dn;
         c_ff.ymod  <= c_in.ymod;
         c_ff.cent  <= c_in.cent;
      end
   end

   assign given = c_ff;

endmodule

@@ rtl/core/calendar_date_counter_core.sv @@
// calendar date counter: held date, day stepping and day difference
//
//   channel  direction  handshake            fields
//   req      in         req_valid/req_stall  func, in_day, in_month, in_year
//   rsp      out        rsp_valid/rsp_stall  now_day, now_month, now_year,
//                                            day_gap, bad_request
//
// one request per cycle unless rsp_stall backs up the pipeline; a result is registered
// once its request has passed stages a, b and c of caldate_daynum, which form the given
// date's day number, and the stage updating the held date and its day number
// synchronous reset gives 1 jan 2000 and empties the pipeline
// rsp_stall holds the result register; earlier stages keep filling until full
module calendar_date_counter_core #(
   parameter int MAX_YEAR = caldate_pkg::MAX_YEAR_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [1:0]                         req_func,
   input  logic [caldate_pkg::DAY_W-1:0]      req_in_day,
   input  logic [caldate_pkg::MONTH_W-1:0]    req_in_month,
   input  logic [caldate_pkg::YEAR_W-1:0]     req_in_year,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [caldate_pkg::DAY_W-1:0]      rsp_now_day,
   output logic [caldate_pkg::MONTH_W-1:0]    rsp_now_month,
   output logic [caldate_pkg::YEAR_W-1:0]     rsp_now_year,
   output logic [caldate_pkg::GAP_W-1:0]      rsp_day_gap,
   output logic                               rsp_bad_request
);

   localparam int YW = caldate_pkg::YEAR_W;
   localparam int DW = caldate_pkg::DN_W;
   localparam int MW = caldate_pkg::YMOD_W;

   caldate_pkg::given_type            given;
   logic                              out_ok, fire;

   logic [caldate_pkg::DAY_W-1:0]     held_day_ff, held_day_in;
   logic [caldate_pkg::MONTH_W-1:0]   held_month_ff, held_month_in;
   logic [YW-1:0]                     held_year_ff, held_year_in;
   logic [DW-1:0]                     held_dn_ff, held_dn_in;
   logic [MW-1:0]                     held_ymod_ff, held_ymod_in;
   logic [caldate_pkg::CENT_W-1:0]    held_cent_ff, held_cent_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic [caldate_pkg::DAY_W-1:0]     rsp_now_day_ff;
   logic [caldate_pkg::MONTH_W-1:0]   rsp_now_month_ff;
   logic [YW-1:0]                     rsp_now_year_ff;
   logic [caldate_pkg::GAP_W-1:0]     rsp_day_gap_ff, rsp_day_gap_in;
   logic                              rsp_bad_request_ff, rsp_bad_request_in;

   logic                              held_leap;
   logic [caldate_pkg::DAY_W-1:0]     held_len;
   logic [DW-1:0]                     gap_abs;

   caldate_daynum #(
      .MAX_YEAR (MAX_YEAR)
   ) u_daynum (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_func     (req_func),
      .req_in_day   (req_in_day),
      .req_in_month (req_in_month),
      .req_in_year  (req_in_year),
      .down_stall   (!out_ok),
      .given        (given)
   );

   assign out_ok       = !rsp_valid_ff || !rsp_stall;
   assign fire         = given.valid && out_ok;
   assign rsp_valid_in = given.valid;

   assign held_leap = caldate_pkg::is_leap(held_ymod_ff, held_cent_ff);
   assign held_len  = caldate_pkg::month_days(held_month_ff, held_leap);
   assign gap_abs   = (held_dn_ff > given.dn) ? (held_dn_ff - given.dn)
                                              : (given.dn - held_dn_ff);

   always_comb begin
      held_day_in        = held_day_ff;
      held_month_in      = held_month_ff;
      held_year_in       = held_year_ff;
      held_dn_in         = held_dn_ff;
      held_ymod_in       = held_ymod_ff;
      held_cent_in       = held_cent_ff;
      rsp_day_gap_in     = '0;
      rsp_bad_request_in = 1'b0;
      case (given.func)
         caldate_pkg::FUNC_SET: begin
            if (given.ok) begin
               held_day_in   = given.day;
               held_month_in = given.month;
               held_year_in  = given.year;
               held_dn_in    = given.dn;
               held_ymod_in  = given.ymod;
               held_cent_in  = given.cent;
            end else begin
               rsp_bad_request_in = 1'b1;
            end
         end
         caldate_pkg::FUNC_NEXT: begin
            if ((held_day_ff == 5'd31) && (held_month_ff == 4'd12)
                && (held_year_ff >= YW'(MAX_YEAR))) begin
               rsp_bad_request_in = 1'b1;
            end else begin
               held_dn_in = held_dn_ff + DW'(1);
               if (held_day_ff >= held_len) begin
                  held_day_in = 5'd1;
                  if (held_month_ff >= 4'd12) begin
                     held_month_in = 4'd1;
                     held_year_in  = held_year_ff + YW'(1);
                     if (held_ymod_ff == MW'(99)) begin
                        held_ymod_in = '0;
                        held_cent_in = held_cent_ff + 2'd1;
                     end else begin
                        held_ymod_in = held_ymod_ff + MW'(1);
                     end
                  end else begin
                     held_month_in = held_month_ff + 4'd1;
                  end
               end else begin
                  held_day_in = held_day_ff + 5'd1;
               end
            end
         end
         caldate_pkg::FUNC_PREV: begin
            if ((held_day_ff == 5'd1) && (held_month_ff == 4'd1)
                && (held_year_ff <= YW'(1))) begin
               rsp_bad_request_in = 1'b1;
            end else begin
               held_dn_in = held_dn_ff - DW'(1);
               if (held_day_ff <= 5'd1) begin
                  if (held_month_ff <= 4'd1) begin
                     held_month_in = 4'd12;
                     held_year_in  = held_year_ff - YW'(1);
                     if (held_ymod_ff == '0) begin
                        held_ymod_in = MW'(99);
                        held_cent_in = held_cent_ff - 2'd1;
                     end else begin
                        held_ymod_in = held_ymod_ff - MW'(1);
                     end
                  end else begin
                     held_month_in = held_month_ff - 4'd1;
                  end
                  // december needs no leap bit; february keeps the same year
                  held_day_in = caldate_pkg::month_days(held_month_in, held_leap);
               end else begin
                  held_day_in = held_day_ff - 5'd1;
               end
            end
         end
         caldate_pkg::FUNC_DIFF: begin
            if (given.ok) begin
               if (gap_abs > DW'(caldate_pkg::GAP_MAX)) begin
                  rsp_day_gap_in = caldate_pkg::GAP_MAX;
               end else begin
                  rsp_day_gap_in = gap_abs[caldate_pkg::GAP_W-1:0];
               end
            end else begin
               rsp_bad_request_in = 1'b1;
            end
         end
         default: begin
            rsp_bad_request_in = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_day_ff   <= 5'd1;
         held_month_ff <= 4'd1;
         held_year_ff  <= YW'(2000);
         held_dn_ff    <= caldate_pkg::DN_RESET;
         held_ymod_ff  <= '0;
         held_cent_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (fire) begin
            held_day_ff   <= held_day_in;
            held_month_ff <= held_month_in;
            held_year_ff  <= held_year_in;
            held_dn_ff    <= held_dn_in;
            held_ymod_ff  <= held_ymod_in;
            held_cent_ff  <= held_cent_in;
         end
         if (out_ok) begin
            rsp_valid_ff <= rsp_valid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_now_day_ff     <= held_day_in;
         rsp_now_month_ff   <= held_month_in;
         rsp_now_year_ff    <= held_year_in;
         rsp_day_gap_ff     <= rsp_day_gap_in;
         rsp_bad_request_ff <= rsp_bad_request_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_now_day     = rsp_now_day_ff;
   assign rsp_now_month   = rsp_now_month_ff;
   assign rsp_now_year    = rsp_now_year_ff;
   assign rsp_day_gap     = rsp_day_gap_ff;
   assign rsp_bad_request = rsp_bad_request_ff;

endmodule

@@ rtl/core/caldate_checker.sv @@
// port-level checker for the calendar date counter, bound to the top level
`include "assert_macros.svh"

module caldate_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic [caldate_pkg::DAY_W-1:0]      rsp_now_day,
   input logic [caldate_pkg::MONTH_W-1:0]    rsp_now_month,
   input logic [caldate_pkg::YEAR_W-1:0]     rsp_now_year,
   input logic [caldate_pkg::GAP_W-1:0]      rsp_day_gap,
   input logic                               rsp_bad_request
);

   localparam int DATA_W = caldate_pkg::YEAR_W + caldate_pkg::MONTH_W
                           + caldate_pkg::DAY_W + caldate_pkg::GAP_W;

   logic [DATA_W-1:0] rsp_data;
   logic              date_plausible;
   logic              short_month;
   logic              len_ok;

   assign rsp_data       = {rsp_now_year, rsp_now_month, rsp_now_day, rsp_day_gap};
   assign date_plausible = (rsp_now_month >= 4'd1) && (rsp_now_month <= 4'd12)
                           && (rsp_now_day >= 5'd1) && (rsp_now_day <= 5'd31)
                           && (rsp_now_year != '0);
   assign short_month    = (rsp_now_month == 4'd4) || (rsp_now_month == 4'd6)
                           || (rsp_now_month == 4'd9) || (rsp_now_month == 4'd11)
                           || (rsp_now_month == 4'd2);
   assign len_ok         = (rsp_now_day <= 5'd30)
                           && ((rsp_now_month != 4'd2) || (rsp_now_day <= 5'd29));

   // a stalled result stays offered
   `CALDATE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)

   // a stalled result keeps its date and gap
   `CALDATE_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_data))

   // held date is always a plausible date
   `CALDATE_ASSERT_IMPL(a_date_range, clock, reset, rsp_valid, date_plausible)

   // short months never hold day 31, february never past 29
   `CALDATE_ASSERT_IMPL(a_month_len, clock, reset, rsp_valid && short_month, len_ok)

   // a rejected request carries no gap
   `CALDATE_ASSERT(a_gap_bad, clock, reset, !(rsp_valid && rsp_bad_request && (rsp_day_gap != '0)))

endmodule

bind calendar_date_counter_core caldate_checker u_caldate_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_now_day     (rsp_now_day),
   .rsp_now_month   (rsp_now_month),
   .rsp_now_year    (rsp_now_year),
   .rsp_day_gap     (rsp_day_gap),
   .rsp_bad_request (rsp_bad_request)
);
